// ===== hw/rtl/wgm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgm_pkg
// shared types and constants for the wildcard glob matcher
// ----------------------------------------------------------------------------
package wgm_pkg;

  // default pattern capacity in characters
  localparam int PATTERN_MAX_DEFAULT = 64;

  // pattern metacharacters
  localparam logic [7:0] STAR_CODE     = 8'h2A;
  localparam logic [7:0] QUESTION_CODE = 8'h3F;

  // word kinds on the input channel
  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_PATTERN = 2'd1,
    KIND_SUBJECT = 2'd2,
    KIND_END     = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] char_code;
  } item_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } result_t;

endpackage

// ===== hw/rtl/wildcard_glob_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_glob_matcher
// streaming glob matcher for '*' and '?' over a loaded pattern
// ----------------------------------------------------------------------------
// path: an accepted word is held in the input register, and its result (end
//   words only) is written from there into the result register
// throughput: one word per cycle unless an end word waits on the result register
// reset (rst, synchronous): empty pattern, no open subject, overflow cleared,
//   both registers empty; pattern bytes themselves are not cleared
// ----------------------------------------------------------------------------
module wildcard_glob_matcher #(
  parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  // input channel
  input  logic             item_valid,
  output logic             item_stall,
  input  wgm_pkg::item_t   item,
  // result channel
  output logic             result_valid,
  input  logic             result_stall,
  output wgm_pkg::result_t result
);

  // prefix-set width: prefixes of length 0 .. PATTERN_MAX
  localparam int SetW   = PATTERN_MAX + 1;
  // levels of the parallel-prefix star closure
  localparam int Levels = $clog2(SetW);

  // input register
  logic           s1_valid;
  wgm_pkg::item_t s1_item;

  // pattern storage, one lane per character position
  logic [7:0]             pat [PATTERN_MAX];
  // thermometer of written positions, bit i set when i < pattern length
  logic [PATTERN_MAX-1:0] active;
  // one-hot marker of the pattern length, bit i set when length == i
  logic [SetW-1:0]        endpos;
  // prefix set of the empty subject: prefix 0 and any leading stars
  logic [SetW-1:0]        start_set;
  // prefixes matching the subject seen so far
  logic [SetW-1:0]        prefix_set;
  logic                   subject_open;
  logic                   overflow_flag;

  // handshake and datapath signals
  logic                   out_free;
  logic                   s1_fire;
  logic                   pat_full;
  logic                   append_ok;
  logic [PATTERN_MAX-1:0] is_star;
  logic [PATTERN_MAX-1:0] is_hit;
  logic [SetW-1:0]        base_set;
  logic [SetW-1:0]        raw_set;
  logic [SetW-1:0]        prop;
  logic [SetW-1:0]        clo_g;
  logic [SetW-1:0]        clo_p;
  logic                   start_star;

  // the result register is free when empty or being drained this cycle
  assign out_free = !result_valid || !result_stall;

  // an end word only moves on when the result register can take it
  assign s1_fire    = s1_valid && ((s1_item.kind != wgm_pkg::KIND_END) || out_free);
  assign item_stall = s1_valid && !s1_fire;

  assign pat_full  = active[PATTERN_MAX-1];
  assign append_ok = (s1_item.kind == wgm_pkg::KIND_PATTERN) && !pat_full;

  // first subject byte starts from the empty-subject prefix set
  assign base_set = subject_open ? prefix_set : start_set;

  // per-lane compare of the stored character against the subject byte
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      is_star[i] = active[i] && (pat[i] == wgm_pkg::STAR_CODE);
      is_hit[i]  = active[i] && ((pat[i] == wgm_pkg::QUESTION_CODE) ||
                                 (pat[i] == s1_item.char_code));
    end
  end

  // one step of the automaton: a star keeps its prefix and also advances,
  // '?' or an equal literal advances
  always_comb begin
    raw_set = '0;
    prop    = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (base_set[i] && is_star[i]) begin
        raw_set[i]   = 1'b1;
        raw_set[i+1] = 1'b1;
      end else if (base_set[i] && is_hit[i]) begin
        raw_set[i+1] = 1'b1;
      end
      // prefix i+1 inherits from prefix i across a star (empty run)
      prop[i+1] = is_star[i];
    end
  end

  // star closure as a log-depth parallel prefix, like a carry lookahead
  always_comb begin
    clo_g = raw_set;
    clo_p = prop;
    for (int s = 0; s < Levels; s++) begin
      clo_g = clo_g | (clo_p & (clo_g << (1 << s)));
      clo_p = clo_p & (clo_p << (1 << s));
    end
  end

  // a star appended right after a leading-star run extends the start set
  assign start_star = (s1_item.char_code == wgm_pkg::STAR_CODE) &&
                      (|(endpos & start_set));

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall) begin
      s1_item <= item;
    end
  end

  // pattern lanes, written at the current length marker
  always_ff @(posedge clk) begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (s1_fire && append_ok && endpos[i]) begin
        pat[i] <= s1_item.char_code;
      end
    end
  end

  // matcher state
  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= '0;
      endpos        <= SetW'(1);
      start_set     <= SetW'(1);
      prefix_set    <= '0;
      subject_open  <= 1'b0;
      overflow_flag <= 1'b0;
    end else if (s1_fire) begin
      case (s1_item.kind)
        wgm_pkg::KIND_CLEAR: begin
          active        <= '0;
          endpos        <= SetW'(1);
          start_set     <= SetW'(1);
          prefix_set    <= '0;
          subject_open  <= 1'b0;
          overflow_flag <= 1'b0;
        end
        wgm_pkg::KIND_PATTERN: begin
          // any open subject is dropped
          subject_open <= 1'b0;
          if (pat_full) begin
            overflow_flag <= 1'b1;
          end else begin
            active <= PATTERN_MAX'({active, 1'b1});
            endpos <= endpos << 1;
            if (start_star) begin
              start_set <= start_set | (endpos << 1);
            end
          end
        end
        wgm_pkg::KIND_SUBJECT: begin
          prefix_set   <= clo_g;
          subject_open <= 1'b1;
        end
        wgm_pkg::KIND_END: begin
          subject_open <= 1'b0;
        end
        default: begin
          subject_open <= subject_open;
        end
      endcase
    end
  end

  // result register: matched when the full-length prefix is set, no overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_fire && (s1_item.kind == wgm_pkg::KIND_END)) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && (s1_item.kind == wgm_pkg::KIND_END)) begin
      result.matched          <= !overflow_flag && (|(base_set & endpos));
      result.pattern_overflow <= overflow_flag;
    end
  end

endmodule
